[hdl/dsbs_pkg.sv]
// Shared types, constants and sine table builder for the damped sine bank synthesizer.
package dsbs_pkg;

    localparam int PARTIAL_SLOTS   = 16;
    localparam int SINE_TABLE_BITS = 10;
    localparam int PHASE_BITS      = 24;

    localparam int SLOT_BITS   = $clog2(PARTIAL_SLOTS);
    localparam int TABLE_SIZE  = 1 << SINE_TABLE_BITS;
    localparam int QUARTER     = 1 << (SINE_TABLE_BITS - 2);
    localparam int LEVEL_BITS  = 16;
    localparam int SINE_BITS   = 16;
    localparam int SAMPLE_BITS = 20;
    localparam int PROD_BITS   = 34;  // 17 x 17 signed
    localparam int ACC_BITS    = SAMPLE_BITS + 15;

    // Port field widths
    localparam int OP_BITS        = 1;
    localparam int IN_SLOT_BITS   = 4;
    localparam int IN_STEP_BITS   = 24;
    localparam int CFG_BITS       = 4;
    localparam int S_TDATA_BITS   = 64;
    localparam int M_TDATA_BITS   = 24;

    localparam logic [LEVEL_BITS-1:0] UNITY = 16'h8000;

    typedef logic [PHASE_BITS-1:0]       phase_t;
    typedef logic [LEVEL_BITS-1:0]       level_t;
    typedef logic [SLOT_BITS-1:0]        slot_t;
    typedef logic signed [SINE_BITS-1:0] sine_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [ACC_BITS-1:0]  acc_t;

    typedef enum logic [OP_BITS-1:0] {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic {
        MUL_DECAY = 1'b0,
        MUL_SINE  = 1'b1
    } mul_sel_t;

    typedef struct packed {
        logic  load;
        logic  advance;
        slot_t slot;
    } bank_ctl_t;

    typedef logic signed [SINE_BITS-1:0] sine_table_t [TABLE_SIZE];

    // Q30 polynomial coefficients of sin(pi/2 * x)
    localparam longint K1  = 64'sd1686629713;
    localparam longint K3  = -64'sd693598342;
    localparam longint K5  = 64'sd85569305;
    localparam longint K7  = -64'sd5026995;
    localparam longint K9  = 64'sd172272;
    localparam longint K11 = -64'sd3864;

    // signed Q30 times unsigned Q30, rounded half away from zero
    function automatic longint q30_mul(longint a, longint unsigned b);
        logic neg;
        longint unsigned m;
        longint unsigned p;
        neg = (a < 0);
        m = neg ? longint'(-a) : a;
        p = (m * b + (64'd1 << 29)) >> 30;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic sine_t quarter_sine(int unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint acc;
        longint unsigned v;
        x   = longint'(r) << (30 - (SINE_TABLE_BITS - 2));
        x2  = (x * x) >> 30;
        acc = K11;
        acc = K9 + q30_mul(acc, x2);
        acc = K7 + q30_mul(acc, x2);
        acc = K5 + q30_mul(acc, x2);
        acc = K3 + q30_mul(acc, x2);
        acc = K1 + q30_mul(acc, x2);
        acc = q30_mul(acc, x);
        if (acc < 0) begin
            acc = 0;
        end
        v = (longint'(acc) + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return sine_t'(v[SINE_BITS-1:0]);
    endfunction

    // full-turn table from quarter-wave symmetry
    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        int unsigned quad;
        int unsigned r;
        sine_t s;
        for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
            quad = i >> (SINE_TABLE_BITS - 2);
            r    = i & (QUARTER - 1);
            s    = quad[0] ? quarter_sine(QUARTER - r) : quarter_sine(r);
            tbl[i] = quad[1] ? -s : s;
        end
        return tbl;
    endfunction

endpackage

[hdl/dsbs_sine_rom.sv]
// Sine lookup ROM with registered read.
module dsbs_sine_rom (
    input  logic                                      aclk,
    input  logic [dsbs_pkg::SINE_TABLE_BITS-1:0]       addr,
    output dsbs_pkg::sine_t                            data
);

    localparam dsbs_pkg::sine_table_t ROM = dsbs_pkg::build_sine_table();

    dsbs_pkg::sine_t data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= ROM[addr];
    end

    assign data = data_reg;

endmodule

[hdl/dsbs_bank.sv]
// Per-partial state: phase, level, increment and decay.
module dsbs_bank (
    input  logic                aclk,
    input  logic                aresetn,
    input  dsbs_pkg::bank_ctl_t ctl,
    input  dsbs_pkg::phase_t    load_inc,
    input  dsbs_pkg::level_t    load_level,
    input  dsbs_pkg::level_t    load_decay,
    input  dsbs_pkg::level_t    new_level,
    output dsbs_pkg::phase_t    rd_phase,
    output dsbs_pkg::level_t    rd_level,
    output dsbs_pkg::level_t    rd_decay
);

    dsbs_pkg::phase_t phase_reg [dsbs_pkg::PARTIAL_SLOTS];
    dsbs_pkg::phase_t inc_reg   [dsbs_pkg::PARTIAL_SLOTS];
    dsbs_pkg::level_t level_reg [dsbs_pkg::PARTIAL_SLOTS];
    dsbs_pkg::level_t decay_reg [dsbs_pkg::PARTIAL_SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < dsbs_pkg::PARTIAL_SLOTS; i++) begin
                phase_reg[i] <= '0;
            end
        end else if (ctl.load) begin
            phase_reg[ctl.slot] <= '0;
        end else if (ctl.advance) begin
            phase_reg[ctl.slot] <= phase_reg[ctl.slot] + inc_reg[ctl.slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            inc_reg[ctl.slot]   <= load_inc;
            level_reg[ctl.slot] <= load_level;
            decay_reg[ctl.slot] <= load_decay;
        end else if (ctl.advance) begin
            level_reg[ctl.slot] <= new_level;
        end
    end

    assign rd_phase = phase_reg[ctl.slot];
    assign rd_level = level_reg[ctl.slot];
    assign rd_decay = decay_reg[ctl.slot];

endmodule

[hdl/dsbs_mul.sv]
// Shared 17x17 signed multiplier with operand select (decay or sine product).
module dsbs_mul (
    input  dsbs_pkg::mul_sel_t sel,
    input  dsbs_pkg::level_t   level,
    input  dsbs_pkg::level_t   decay,
    input  dsbs_pkg::level_t   level_hold,
    input  dsbs_pkg::sine_t    sine,
    output dsbs_pkg::prod_t    product
);

    logic signed [dsbs_pkg::LEVEL_BITS:0] op_a;
    logic signed [dsbs_pkg::LEVEL_BITS:0] op_b;

    always_comb begin
        unique case (sel)
            dsbs_pkg::MUL_DECAY: begin
                op_a = signed'({1'b0, level});
                op_b = signed'({1'b0, decay});
            end
            dsbs_pkg::MUL_SINE: begin
                op_a = {sine[dsbs_pkg::SINE_BITS-1], sine};
                op_b = signed'({1'b0, level_hold});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign product = op_a * op_b;

endmodule

[hdl/damped_sine_bank_synth.sv]
// Top level of the damped sine bank synthesizer: sequencer, accumulator and ports.
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+-----------------------------------------
//  s_       | in  | s_tvalid / s_tready       | s_tuser: operation; s_tdata: slot,
//           |     |                           |   phase_step, start_level, decay_factor
//  m_       | out | m_tvalid / m_tready       | m_tdata: sample
//  cfg_     | in  | cfg_we (no back-pressure) | cfg_wdata: active_partials
//
// A load beat is done in its accept. A tick beat for n active partials walks these states:
// the accept in idle, then per partial a fetch state for the ROM read and decay product and a
// multiply state for the sine product, both through the single shared multiplier, then a post state.
// s_tready is low while a tick is in flight; loads go through while a sample waits on m_.
// A finished tick holds in its last step until the output register is free.
// aresetn (synchronous) clears all phases, sets active_partials to 1, empties the output.
module damped_sine_bank_synth (
    input  logic                                aclk,
    input  logic                                aresetn,
    // config
    input  logic                                cfg_we,
    input  logic [dsbs_pkg::CFG_BITS-1:0]       cfg_wdata,   // active_partials
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dsbs_pkg::S_TDATA_BITS-1:0]   s_tdata,     // [3:0] slot, [27:4] phase_step,
                                                             // [43:28] start_level,
                                                             // [59:44] decay_factor, rest 0
    input  logic [dsbs_pkg::OP_BITS-1:0]        s_tuser,     // [0] operation
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dsbs_pkg::M_TDATA_BITS-1:0]   m_tdata      // [19:0] sample, rest 0
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_DONE
    } state_t;

    localparam int F_SLOT  = 0;
    localparam int F_STEP  = F_SLOT + dsbs_pkg::IN_SLOT_BITS;
    localparam int F_LEVEL = F_STEP + dsbs_pkg::IN_STEP_BITS;
    localparam int F_DECAY = F_LEVEL + dsbs_pkg::LEVEL_BITS;

    state_t                               state_reg;
    logic [dsbs_pkg::CFG_BITS-1:0]        active_reg;
    dsbs_pkg::slot_t                      idx_reg;
    dsbs_pkg::slot_t                      last_reg;
    dsbs_pkg::level_t                     level_hold_reg;
    dsbs_pkg::acc_t                       acc_reg;
    logic                                 m_tvalid_reg;
    logic [dsbs_pkg::SAMPLE_BITS-1:0]     sample_reg;

    // input fields
    logic [dsbs_pkg::IN_SLOT_BITS-1:0]    in_slot;
    logic [dsbs_pkg::IN_STEP_BITS-1:0]    in_step;
    dsbs_pkg::level_t                     in_level;
    dsbs_pkg::level_t                     in_decay;
    logic [31:0]                          slot_ext;
    logic                                 slot_ok;
    dsbs_pkg::level_t                     sat_level;
    dsbs_pkg::level_t                     sat_decay;
    logic                                 accept;
    logic                                 is_tick;

    // active count, saturated to one below the bank size
    logic [31:0]                          n_ext;
    dsbs_pkg::slot_t                      n_eff;

    dsbs_pkg::bank_ctl_t                  bank_ctl;
    dsbs_pkg::phase_t                     rd_phase;
    dsbs_pkg::level_t                     rd_level;
    dsbs_pkg::level_t                     rd_decay;
    dsbs_pkg::sine_t                      sine;
    dsbs_pkg::mul_sel_t                   mul_sel;
    dsbs_pkg::prod_t                      product;
    dsbs_pkg::level_t                     new_level;
    dsbs_pkg::acc_t                       acc_rnd;
    logic                                 out_free;

    assign in_slot  = s_tdata[F_SLOT  +: dsbs_pkg::IN_SLOT_BITS];
    assign in_step  = s_tdata[F_STEP  +: dsbs_pkg::IN_STEP_BITS];
    assign in_level = s_tdata[F_LEVEL +: dsbs_pkg::LEVEL_BITS];
    assign in_decay = s_tdata[F_DECAY +: dsbs_pkg::LEVEL_BITS];

    assign slot_ext  = 32'(in_slot);
    assign slot_ok   = (slot_ext < 32'(dsbs_pkg::PARTIAL_SLOTS));
    assign sat_level = (in_level > dsbs_pkg::UNITY) ? dsbs_pkg::UNITY : in_level;
    assign sat_decay = (in_decay > dsbs_pkg::UNITY) ? dsbs_pkg::UNITY : in_decay;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = (s_tuser == dsbs_pkg::OP_TICK);

    assign n_ext = (32'(active_reg) > 32'(dsbs_pkg::PARTIAL_SLOTS - 1))
                 ? 32'(dsbs_pkg::PARTIAL_SLOTS - 1) : 32'(active_reg);
    assign n_eff = n_ext[dsbs_pkg::SLOT_BITS-1:0];

    // bank port: load slot while idle, walking index otherwise
    assign bank_ctl.load    = accept && !is_tick && slot_ok;
    assign bank_ctl.advance = (state_reg == ST_FETCH);
    assign bank_ctl.slot    = (state_reg == ST_IDLE) ? slot_ext[dsbs_pkg::SLOT_BITS-1:0]
                                                     : idx_reg;

    dsbs_bank u_bank (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (bank_ctl),
        .load_inc   (dsbs_pkg::phase_t'(in_step)),
        .load_level (sat_level),
        .load_decay (sat_decay),
        .new_level  (new_level),
        .rd_phase   (rd_phase),
        .rd_level   (rd_level),
        .rd_decay   (rd_decay)
    );

    // phase truncated to the table index
    dsbs_sine_rom u_rom (
        .aclk (aclk),
        .addr (rd_phase[dsbs_pkg::PHASE_BITS-1 -: dsbs_pkg::SINE_TABLE_BITS]),
        .data (sine)
    );

    // fetch cycle: level * decay; multiply cycle: sine * old level
    assign mul_sel = (state_reg == ST_FETCH) ? dsbs_pkg::MUL_DECAY : dsbs_pkg::MUL_SINE;

    dsbs_mul u_mul (
        .sel        (mul_sel),
        .level      (rd_level),
        .decay      (rd_decay),
        .level_hold (level_hold_reg),
        .sine       (sine),
        .product    (product)
    );

    // level * decay <= 2^30, so bits [30:15] hold the floored quotient
    assign new_level = product[15 +: dsbs_pkg::LEVEL_BITS];

    // round half up: floor((sum + 2^14) / 2^15)
    assign acc_rnd  = acc_reg + dsbs_pkg::acc_t'(16384);
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= dsbs_pkg::CFG_BITS'(1);
        end else if (cfg_we) begin
            active_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
        end else begin
            // a posted sample refills the output in the cycle the old beat leaves
            if (state_reg == ST_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && is_tick) begin
                        idx_reg  <= '0;
                        last_reg <= n_eff - 1'b1;
                        acc_reg  <= '0;
                        state_reg <= (n_eff == '0) ? ST_DONE : ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    level_hold_reg <= rd_level;
                    state_reg      <= ST_MUL;
                end
                ST_MUL: begin
                    acc_reg <= acc_reg + dsbs_pkg::acc_t'(product);
                    idx_reg <= idx_reg + 1'b1;
                    state_reg <= (idx_reg == last_reg) ? ST_DONE : ST_FETCH;
                end
                ST_DONE: begin
                    if (out_free) begin
                        sample_reg   <= acc_rnd[15 +: dsbs_pkg::SAMPLE_BITS];
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(dsbs_pkg::M_TDATA_BITS - dsbs_pkg::SAMPLE_BITS){1'b0}}, sample_reg};

endmodule

[hdl/dsbs_checker.sv]
// Port-level checks for the damped sine bank synthesizer, bound to the top level.
module dsbs_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [dsbs_pkg::OP_BITS-1:0]        s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [dsbs_pkg::M_TDATA_BITS-1:0]   m_tdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // a tick keeps the input closed while it runs
    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == dsbs_pkg::OP_TICK) |=> !s_tready)
        else $error("input ready right after a tick beat");

    // a load never makes a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == dsbs_pkg::OP_LOAD) && !m_tvalid |=> !m_tvalid)
        else $error("result after a load beat");

    // reset empties the output and opens the input
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output or input state not cleared by reset");

endmodule

bind damped_sine_bank_synth dsbs_checker u_dsbs_checker (.*);

[verif/damped_sine_bank_synth_tb.sv]
// Self-checking testbench for the damped sine bank synthesizer: loads, ticks, config sweeps.
module damped_sine_bank_synth_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run limits
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 40;     // outlasts a tick with 15 partials
    localparam int IDLE_PCT      = 29;

    // Taylor coefficients of sin(pi/2 * x), Q30
    localparam longint TAYLOR_C1  = 64'sd1686629713;
    localparam longint TAYLOR_C3  = -64'sd693598342;
    localparam longint TAYLOR_C5  = 64'sd85569305;
    localparam longint TAYLOR_C7  = -64'sd5026995;
    localparam longint TAYLOR_C9  = 64'sd172272;
    localparam longint TAYLOR_C11 = -64'sd3864;

    typedef logic signed [dsbs_pkg::SAMPLE_BITS-1:0] sample_t;

    // DUT inputs, known from time zero
    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [dsbs_pkg::CFG_BITS-1:0]      cfg_wdata = '0;
    logic                               s_tvalid  = 1'b0;
    logic [dsbs_pkg::S_TDATA_BITS-1:0]  s_tdata   = '0;
    logic [dsbs_pkg::OP_BITS-1:0]       s_tuser   = '0;
    logic                               m_tready  = 1'b0;
    logic                               s_tready;
    logic                               m_tvalid;
    logic [dsbs_pkg::M_TDATA_BITS-1:0]  m_tdata;

    damped_sine_bank_synth u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),   // active_partials
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [3:0] slot, [27:4] phase_step, [43:28] start_level,
                                  // [59:44] decay_factor, rest 0
        .s_tuser   (s_tuser),     // [0] operation
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)      // [19:0] sample, rest 0
    );

    // 50 MHz clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: private copy of the partial bank and the config
    // ------------------------------------------------------------------
    int                 sine_lut [dsbs_pkg::TABLE_SIZE];
    dsbs_pkg::phase_t   bank_phase [dsbs_pkg::PARTIAL_SLOTS];
    dsbs_pkg::level_t   bank_level [dsbs_pkg::PARTIAL_SLOTS];
    dsbs_pkg::phase_t   bank_step  [dsbs_pkg::PARTIAL_SLOTS];
    dsbs_pkg::level_t   bank_decay [dsbs_pkg::PARTIAL_SLOTS];
    int unsigned        active_count = 1;     // reset value of active_partials
    sample_t            expected_samples [$];

    int             error_count  = 0;
    int             result_count = 0;
    int             cycle_count  = 0;

    // Traffic shaping knobs, owned by the test sequence
    bit             src_idle_on  = 1'b1;
    bit             sink_idle_on = 1'b1;
    bit             offering     = 1'b0;  // s_tvalid currently high
    int             hold_request = 0;     // long back-pressure request, in cycles
    int             hold_left    = 0;

    // Q30 signed times nonnegative Q30, rounded half away from zero
    function automatic longint q30_round_mul(longint a, longint b);
        longint mag;
        longint p;
        mag = (a < 0) ? -a : a;
        p   = (mag * b + (64'sd1 << 29)) >>> 30;
        return (a < 0) ? -p : p;
    endfunction

    // First-quadrant sine in Q15 from the Horner-evaluated polynomial
    function automatic int quadrant_sine_q15(int r);
        longint x;
        longint x2;
        longint acc;
        longint v;
        x   = longint'(r) << (30 - (dsbs_pkg::SINE_TABLE_BITS - 2));
        x2  = (x * x) >>> 30;
        acc = TAYLOR_C11;
        acc = TAYLOR_C9 + q30_round_mul(acc, x2);
        acc = TAYLOR_C7 + q30_round_mul(acc, x2);
        acc = TAYLOR_C5 + q30_round_mul(acc, x2);
        acc = TAYLOR_C3 + q30_round_mul(acc, x2);
        acc = TAYLOR_C1 + q30_round_mul(acc, x2);
        acc = q30_round_mul(acc, x);
        if (acc < 0) begin
            acc = 0;
        end
        v = (acc + 64'sd16384) >>> 15;
        if (v > 32767) begin
            v = 32767;
        end
        return int'(v);
    endfunction

    // Apply one accepted beat to the bank; ticks queue the sample they produce
    task automatic predict_beat(dsbs_pkg::op_t op, dsbs_pkg::slot_t slot,
                                dsbs_pkg::phase_t step, dsbs_pkg::level_t lvl,
                                dsbs_pkg::level_t dec);
        int unsigned n;
        longint      acc;
        longint      rounded;
        if (op == dsbs_pkg::OP_LOAD) begin
            // levels and decays above unity saturate; the phase restarts
            bank_step[slot]  = step;
            bank_level[slot] = (lvl > dsbs_pkg::UNITY) ? dsbs_pkg::UNITY : lvl;
            bank_decay[slot] = (dec > dsbs_pkg::UNITY) ? dsbs_pkg::UNITY : dec;
            bank_phase[slot] = '0;
        end else begin
            n   = (active_count > 32'(dsbs_pkg::PARTIAL_SLOTS - 1))
                ? 32'(dsbs_pkg::PARTIAL_SLOTS - 1) : active_count;
            acc = 0;
            for (int j = 0; j < n; j++) begin
                acc += longint'(sine_lut[bank_phase[j][dsbs_pkg::PHASE_BITS-1 -:
                                                       dsbs_pkg::SINE_TABLE_BITS]])
                       * longint'(bank_level[j]);
                bank_level[j] = dsbs_pkg::level_t'(
                    (32'(bank_level[j]) * 32'(bank_decay[j])) >> 15);
                bank_phase[j] = bank_phase[j] + bank_step[j];
            end
            rounded = (acc + 64'sd16384) >>> 15;   // floor, so ties go up
            expected_samples.push_back(sample_t'(rounded));
        end
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Sender: one beat per call, left offered so back-to-back beats need
    // no drop of tvalid; with source idling on, a random gap lowers it.
    // Must be called at a rising edge.
    // ------------------------------------------------------------------
    task automatic send_beat(dsbs_pkg::op_t op, dsbs_pkg::slot_t slot, dsbs_pkg::phase_t step,
                             dsbs_pkg::level_t lvl, dsbs_pkg::level_t dec);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, dec, lvl, step, slot};
        offering  = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        predict_beat(op, slot, step, lvl, dec);
        if (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            offering  = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Random beat; loads get mostly musical content, with some raw 16-bit values
    task automatic send_random_beat(int tick_pct);
        dsbs_pkg::op_t    op;
        dsbs_pkg::phase_t step;
        dsbs_pkg::level_t lvl;
        dsbs_pkg::level_t dec;
        int               pick;
        op   = ($urandom_range(99) < tick_pct) ? dsbs_pkg::OP_TICK : dsbs_pkg::OP_LOAD;
        pick = $urandom_range(99);
        if (pick < 50)      step = dsbs_pkg::phase_t'($urandom_range(0, 24'h03FFFF));
        else if (pick < 90) step = dsbs_pkg::phase_t'($urandom);
        else                step = pick[0] ? '1 : '0;
        pick = $urandom_range(99);
        if (pick < 70)      lvl = dsbs_pkg::level_t'($urandom_range(0, dsbs_pkg::UNITY));
        else if (pick < 90) lvl = dsbs_pkg::level_t'($urandom);
        else                lvl = pick[0] ? dsbs_pkg::UNITY : '0;
        pick = $urandom_range(99);
        if (pick < 60)      dec = dsbs_pkg::level_t'($urandom_range(29000, dsbs_pkg::UNITY));
        else if (pick < 85) dec = dsbs_pkg::level_t'($urandom);
        else                dec = dsbs_pkg::level_t'($urandom_range(0, dsbs_pkg::UNITY));
        send_beat(op, dsbs_pkg::slot_t'($urandom), step, lvl, dec);
    endtask

    // Stop offering and wait for the bank to go quiet. A load leaves no
    // result behind, so wait out a full tick after the last sample.
    task automatic drain_bank();
        if (offering) begin
            s_tvalid <= 1'b0;
            offering  = 1'b0;
        end
        while (expected_samples.size() > 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Config write, only from an idle bank
    task automatic write_active_partials(int unsigned count);
        drain_bank();
        cfg_we    <= 1'b1;
        cfg_wdata <= dsbs_pkg::CFG_BITS'(count);
        @(posedge aclk);
        active_count = count;
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every slot loaded; slots 0-3 with edge values: zero and full-scale steps,
    // levels and decays at 0, unity and above unity (saturation).
    task automatic test_partial_load_extremes();
        dsbs_pkg::phase_t step;
        dsbs_pkg::level_t lvl;
        dsbs_pkg::level_t dec;
        for (int i = 0; i < dsbs_pkg::PARTIAL_SLOTS; i++) begin
            unique case (i)
                0: begin
                    step = '0;      lvl = dsbs_pkg::UNITY;   dec = dsbs_pkg::UNITY;
                end
                1: begin
                    step = '1;      lvl = '1;      dec = '1;
                end
                2: begin
                    step = 24'h400000; lvl = '0;   dec = '0;
                end
                3: begin
                    step = 24'h7FFFFF;
                    lvl  = dsbs_pkg::level_t'(dsbs_pkg::UNITY + 16'd1);
                    dec  = dsbs_pkg::level_t'(dsbs_pkg::UNITY + 16'd1);
                end
                default: begin
                    step = dsbs_pkg::phase_t'(i * 24'h012345);
                    lvl  = dsbs_pkg::level_t'(dsbs_pkg::UNITY - i * 1000);
                    dec  = dsbs_pkg::level_t'(dsbs_pkg::UNITY - i * 7);
                end
            endcase
            send_beat(dsbs_pkg::OP_LOAD, dsbs_pkg::slot_t'(i), step, lvl, dec);
        end
        // default config: only slot 0 sums
        send_beat(dsbs_pkg::OP_TICK, '0, '0, '0, '0);
        send_beat(dsbs_pkg::OP_TICK, '1, '1, '1, '1);
    endtask

    // Widest and empty bank; a load mid-run restarts its partial's phase
    task automatic test_active_count_extremes();
        write_active_partials(dsbs_pkg::PARTIAL_SLOTS - 1);
        send_beat(dsbs_pkg::OP_TICK, '0, '0, '0, '0);
        send_beat(dsbs_pkg::OP_TICK, '0, '0, '0, '0);
        send_beat(dsbs_pkg::OP_LOAD, dsbs_pkg::slot_t'(5), 24'h100000,
                  dsbs_pkg::UNITY, dsbs_pkg::UNITY);
        send_beat(dsbs_pkg::OP_TICK, '0, '0, '0, '0);
        write_active_partials(0);
        send_beat(dsbs_pkg::OP_TICK, '1, '1, '1, '1);
    endtask

    // Mixed traffic across several partial counts, both sides idling
    task automatic test_random_bank_traffic();
        int unsigned counts [6] = '{15, 0, 7, 1, 0, 15};
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        counts[4]    = $urandom_range(2, 14);
        foreach (counts[p]) begin
            write_active_partials(counts[p]);
            repeat (90) send_random_beat(60);
        end
    endtask

    // Long stretch with no idling on either side
    task automatic test_steady_streaming();
        write_active_partials(dsbs_pkg::PARTIAL_SLOTS - 1);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (60) send_random_beat(70);
        drain_bank();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering: the output
    // register fills, the finished tick parks, and s_tready drops.
    task automatic test_output_backpressure();
        write_active_partials(4);
        src_idle_on  = 1'b0;
        hold_request = 400;
        repeat (16) send_random_beat(75);
        drain_bank();
        src_idle_on  = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver throttle. m_tready only changes here.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch($sformatf("unexpected sample %0d",
                                              $signed(m_tdata[dsbs_pkg::SAMPLE_BITS-1:0])));
                end else begin
                    if (m_tdata[dsbs_pkg::SAMPLE_BITS-1:0] !== expected_samples[0]) begin
                        report_mismatch($sformatf("sample %0d: got %0d expected %0d",
                                                  result_count,
                                                  $signed(m_tdata[dsbs_pkg::SAMPLE_BITS-1:0]),
                                                  expected_samples[0]));
                    end
                    void'(expected_samples.pop_front());
                end
                result_count++;
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (sink_idle_on) begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // sine table by quarter-wave symmetry
        for (int i = 0; i < dsbs_pkg::TABLE_SIZE; i++) begin
            int q;
            int r;
            int s;
            q = i >> (dsbs_pkg::SINE_TABLE_BITS - 2);
            r = i & (dsbs_pkg::QUARTER - 1);
            s = q[0] ? quadrant_sine_q15(dsbs_pkg::QUARTER - r) : quadrant_sine_q15(r);
            sine_lut[i] = q[1] ? -s : s;
        end
        foreach (bank_phase[i]) begin
            bank_phase[i] = '0;
        end

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_partial_load_extremes();
        test_active_count_extremes();
        test_random_bank_traffic();
        test_steady_streaming();
        test_output_backpressure();
        drain_bank();

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
